// File: rtl/nvrf_pkg.sv
// ----------------------------------------------------------------------------
// nvrf_pkg
// Shared constants, codes and types of the VF register block.
// ----------------------------------------------------------------------------
package nvrf_pkg;

  localparam int RegisterWords = 4096;
  localparam int WordBits      = 12;

  // Register word indexes
  localparam logic [11:0] W_CTRL      = 12'h000;
  localparam logic [11:0] W_STATUS    = 12'h002;
  localparam logic [11:0] W_NEWICR    = 12'h03C;
  localparam logic [11:0] W_INJICR    = 12'h03D;
  localparam logic [11:0] W_MBXBUF0   = 12'h200;
  localparam logic [11:0] W_MBXBUF1   = 12'h201;
  localparam logic [11:0] W_MBXBUF2   = 12'h202;
  localparam logic [11:0] W_MBXCTL    = 12'h310;
  localparam logic [11:0] W_TIMER     = 12'h412;
  localparam logic [11:0] W_ICS       = 12'h548;
  localparam logic [11:0] W_IMS       = 12'h549;
  localparam logic [11:0] W_IMC       = 12'h54A;
  localparam logic [11:0] W_ICR       = 12'h560;
  localparam logic [11:0] W_IVARMISC  = 12'h5D0;
  localparam logic [11:0] W_QUEUEBASE = 12'h800;
  localparam logic [11:0] W_SRRCTL0   = 12'hA03;
  localparam logic [11:0] W_SRRCTL1   = 12'hA43;

  // Values
  localparam logic [31:0] STATUS_VALUE = 32'h0000_0083;
  localparam logic [31:0] MBXCTL_RESET = 32'h0000_0080;
  localparam logic [31:0] SRRCTL_VALUE = 32'h0000_0400;
  localparam logic [31:0] ACK_BIT      = 32'h8000_0000;
  localparam logic [31:0] NACK_BIT     = 32'h4000_0000;
  localparam logic [31:0] CTS_BIT      = 32'h2000_0000;
  localparam logic [31:0] MBX_RC_MASK  = 32'h0000_00B0;

  // Mailbox requests
  localparam logic [15:0] REQ_RESET = 16'd1;
  localparam logic [15:0] REQ_SETMAC = 16'd2;
  localparam logic [15:0] REQ_MCAST = 16'd3;

  // Input kinds
  localparam logic [2:0] KIND_REG_RD  = 3'd0;
  localparam logic [2:0] KIND_REG_WR  = 3'd1;
  localparam logic [2:0] KIND_MSIX_RD = 3'd2;
  localparam logic [2:0] KIND_MSIX_WR = 3'd3;
  localparam logic [2:0] KIND_INJECT  = 3'd4;
  localparam logic [2:0] KIND_DEV_RST = 3'd5;

  // MSI-X entry word select
  localparam logic [1:0] MX_ADDR_LO = 2'd0;
  localparam logic [1:0] MX_ADDR_HI = 2'd1;
  localparam logic [1:0] MX_DATA    = 2'd2;
  localparam logic [1:0] MX_CTRL    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RD    = 4'b0010,
    ST_INJ   = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  typedef struct packed {
    logic        en;
    logic [11:0] word;
    logic [31:0] data;
  } msix_wr_t;

  // Reset contents of a register store word
  function automatic logic [31:0] default_word(input logic [11:0] addr);
    logic [31:0] v;
    v = '0;
    if (addr == W_SRRCTL0) v = SRRCTL_VALUE;
    if (addr == W_SRRCTL1) v = SRRCTL_VALUE | ACK_BIT;
    return v;
  endfunction

endpackage

// File: rtl/nic_vf_register_file_mailbox_irq_core.sv
// ----------------------------------------------------------------------------
// nic_vf_register_file_mailbox_irq_core
// VF register block with PF mailbox, interrupt registers and MSI-X table.
//
//   channel  signals                                        direction
//   in       in_valid/in_ready, kind, word_offset, write_data  input
//   out      out_valid/out_ready, read_data, msi_valid,        output
//            msi_address, msi_data, last
//   cfg      cfg_we, cfg_data (default MAC)                     input
//
// Writes and MSI-X writes apply when accepted; a read goes through the read
// state, which registers the result. Inject sends one MSI-X message per
// fired vector, paced by out_ready. A pass on reset or device reset restores
// all 4096 store words; one on a toggle of ctrl bit 26, the 2048 queue words.
// in_ready is low during a pass, while a read or inject is being worked off
// and while a result cannot be placed.
// ----------------------------------------------------------------------------
module nic_vf_register_file_mailbox_irq_core
  import nvrf_pkg::*;
#(
  parameter int VECTOR_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [11:0] word_offset,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        msi_valid,
  output logic [63:0] msi_address,
  output logic [31:0] msi_data,
  output logic        last
);

  state_t      state;
  logic [11:0] sweep_addr;
  logic [2:0]  op_kind;
  logic [11:0] op_word;
  logic [VECTOR_COUNT-1:0] fire;

  logic [47:0] dmac;
  logic [47:0] mac;
  logic [31:0] ctrl;
  logic [31:0] newicr;
  logic [31:0] injicr;
  logic [31:0] mbxbuf0;
  logic [31:0] mbxbuf1;
  logic [31:0] mbxbuf2;
  logic [31:0] mbxctl;
  logic [31:0] ims;
  logic [31:0] icr;
  logic [31:0] ivarmisc;

  logic        acc;
  logic        plain_word;
  logic        mem_we;
  logic [11:0] mem_waddr;
  logic [31:0] mem_wdata;
  logic [31:0] mem_rdata;
  logic [31:0] msix_rdata;
  logic [63:0] sel_address;
  logic [31:0] sel_data;
  logic [VECTOR_COUNT-1:0] masked;
  logic [VECTOR_COUNT-1:0] low;
  logic        dev_clear;
  msix_wr_t    mwr;

  logic [31:0] misc_bits;
  logic [31:0] mbx_buf0_next;
  logic [31:0] mbx_buf1_next;
  logic [31:0] mbx_buf2_next;
  logic [31:0] mbx_ctl_next;
  logic [47:0] mac_next;
  logic [31:0] raise_next;

  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign acc       = in_valid && in_ready;
  assign dev_clear = acc && (kind == KIND_DEV_RST);
  assign low       = fire & (~fire + 1'b1);

  // Words held outside the store
  always_comb begin
    plain_word = 1'b1;
    case (word_offset)
      W_CTRL, W_STATUS, W_NEWICR, W_INJICR, W_MBXBUF0, W_MBXBUF1, W_MBXBUF2,
      W_MBXCTL, W_TIMER, W_ICS, W_IMS, W_IMC, W_ICR, W_IVARMISC:
        plain_word = 1'b0;
      default: plain_word = 1'b1;
    endcase
  end

  // Store write port: clearing pass or plain write
  always_comb begin
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = default_word(sweep_addr);
    end else begin
      mem_we    = acc && (kind == KIND_REG_WR) && plain_word;
      mem_waddr = word_offset;
      mem_wdata = write_data;
    end
  end

  assign mwr.en   = acc && (kind == KIND_MSIX_WR);
  assign mwr.word = word_offset;
  assign mwr.data = write_data;

  // Mailbox control write
  always_comb begin
    misc_bits = '0;
    if (ivarmisc[7] && ivarmisc[1:0] != 2'd3) begin
      misc_bits = 32'd1 << ivarmisc[1:0];
    end
    mbx_buf0_next = mbxbuf0;
    mbx_buf1_next = mbxbuf1;
    mbx_buf2_next = mbxbuf2;
    mac_next      = mac;
    raise_next    = '0;
    mbx_ctl_next  = write_data & ~32'd3;
    if (write_data[0]) begin
      if (mbxbuf0[15:0] == REQ_RESET) begin
        mbx_buf0_next = mbxbuf0 | ACK_BIT;
        mbx_buf1_next = mac[31:0];
        mbx_buf2_next = {16'd0, mac[47:32]};
      end else if (mbxbuf0[15:0] == REQ_SETMAC) begin
        mbx_buf0_next = mbxbuf0 | ACK_BIT;
        mac_next      = {mbxbuf2[15:0], mbxbuf1};
      end else if (mbxbuf0[15:0] == REQ_MCAST) begin
        mbx_buf0_next = mbxbuf0 | ACK_BIT | CTS_BIT;
      end else begin
        mbx_buf0_next = mbxbuf0 | NACK_BIT;
      end
      mbx_ctl_next = (mbx_ctl_next & ~32'd4) | 32'h38;
      raise_next   = misc_bits;
    end else if (write_data[1]) begin
      mbx_ctl_next = mbx_ctl_next & ~32'd8;
    end
  end

  // Sequencer and register state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
      dmac       <= '0;
      mac        <= '0;
      ctrl       <= '0;
      newicr     <= '0;
      injicr     <= '0;
      mbxbuf0    <= '0;
      mbxbuf1    <= '0;
      mbxbuf2    <= '0;
      mbxctl     <= MBXCTL_RESET;
      ims        <= '0;
      icr        <= '0;
      ivarmisc   <= '0;
      fire       <= '0;
    end else begin
      if (cfg_we) begin
        dmac <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            op_kind <= kind;
            op_word <= word_offset;
            case (kind)
              KIND_REG_RD, KIND_MSIX_RD: state <= ST_RD;
              KIND_REG_WR: begin
                case (word_offset)
                  W_IMS:      ims <= ims | write_data;
                  W_IMC:      ims <= ims & ~write_data;
                  W_ICR:      icr <= icr & ~write_data;
                  W_ICS: begin
                    icr    <= icr | write_data;
                    newicr <= newicr | write_data;
                  end
                  W_CTRL: begin
                    ctrl <= write_data;
                    if (ctrl[26] != write_data[26]) begin
                      ims        <= '0;
                      mbxctl     <= MBXCTL_RESET;
                      sweep_addr <= W_QUEUEBASE;
                      state      <= ST_SWEEP;
                    end
                  end
                  W_NEWICR:   newicr   <= write_data;
                  W_INJICR:   injicr   <= write_data;
                  W_MBXBUF0:  mbxbuf0  <= write_data;
                  W_MBXBUF1:  mbxbuf1  <= write_data;
                  W_MBXBUF2:  mbxbuf2  <= write_data;
                  W_IVARMISC: ivarmisc <= write_data;
                  W_MBXCTL: begin
                    mbxctl  <= mbx_ctl_next;
                    mbxbuf0 <= mbx_buf0_next;
                    mbxbuf1 <= mbx_buf1_next;
                    mbxbuf2 <= mbx_buf2_next;
                    mac     <= mac_next;
                    icr     <= icr | raise_next;
                    newicr  <= newicr | raise_next;
                  end
                  default: ;
                endcase
              end
              KIND_INJECT: begin
                fire   <= injicr[VECTOR_COUNT-1:0] & ~masked;
                injicr <= '0;
                state  <= ST_INJ;
              end
              KIND_DEV_RST: begin
                mac        <= dmac;
                ctrl       <= '0;
                newicr     <= '0;
                injicr     <= '0;
                mbxbuf0    <= '0;
                mbxbuf1    <= '0;
                mbxbuf2    <= '0;
                mbxctl     <= MBXCTL_RESET;
                ims        <= '0;
                icr        <= '0;
                ivarmisc   <= '0;
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_RD: begin
          out_valid   <= 1'b1;
          msi_valid   <= 1'b0;
          msi_address <= '0;
          msi_data    <= '0;
          last        <= 1'b1;
          if (op_kind == KIND_MSIX_RD) begin
            read_data <= msix_rdata;
          end else begin
            case (op_word)
              W_CTRL:     read_data <= ctrl;
              W_STATUS:   read_data <= STATUS_VALUE;
              W_NEWICR:   read_data <= newicr;
              W_INJICR:   read_data <= injicr;
              W_MBXBUF0:  read_data <= mbxbuf0;
              W_MBXBUF1:  read_data <= mbxbuf1;
              W_MBXBUF2:  read_data <= mbxbuf2;
              W_IMS:      read_data <= ims;
              W_IVARMISC: read_data <= ivarmisc;
              W_ICS, W_IMC: read_data <= '0;
              W_ICR: begin
                read_data <= icr;
                icr       <= '0;
              end
              W_MBXCTL: begin
                read_data <= mbxctl;
                mbxctl    <= mbxctl & ~(mbxctl & MBX_RC_MASK);
              end
              default:    read_data <= mem_rdata;
            endcase
          end
          state <= ST_IDLE;
        end
        ST_INJ: begin
          if (fire == '0) begin
            state <= ST_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            read_data   <= '0;
            msi_valid   <= 1'b1;
            msi_address <= sel_address;
            msi_data    <= sel_data;
            last        <= ((fire & ~low) == '0);
            fire        <= fire & ~low;
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 12'd1;
          if (sweep_addr == 12'hFFF) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  nvrf_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (word_offset),
    .rdata (mem_rdata)
  );

  nvrf_msix #(
    .VECTOR_COUNT (VECTOR_COUNT)
  ) u_msix (
    .clk         (clk),
    .rst         (rst),
    .clear       (dev_clear),
    .wr          (mwr),
    .rd_word     (op_word),
    .rd_data     (msix_rdata),
    .sel         (low),
    .sel_address (sel_address),
    .sel_data    (sel_data),
    .masked      (masked)
  );

endmodule

// File: rtl/nvrf_store.sv
// ----------------------------------------------------------------------------
// nvrf_store
// Register store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nvrf_store
  import nvrf_pkg::*;
(
  input  logic        clk,
  input  logic        we,
  input  logic [11:0] waddr,
  input  logic [31:0] wdata,
  input  logic [11:0] raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [RegisterWords];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/nvrf_msix.sv
// ----------------------------------------------------------------------------
// nvrf_msix
// MSI-X vector table: address, data and mask per vector.
// ----------------------------------------------------------------------------
module nvrf_msix
  import nvrf_pkg::*;
#(
  parameter int VECTOR_COUNT = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  msix_wr_t                wr,
  input  logic [11:0]             rd_word,
  output logic [31:0]             rd_data,
  input  logic [VECTOR_COUNT-1:0] sel,
  output logic [63:0]             sel_address,
  output logic [31:0]             sel_data,
  output logic [VECTOR_COUNT-1:0] masked
);

  logic [63:0] vaddr [VECTOR_COUNT];
  logic [31:0] vdata [VECTOR_COUNT];

  // Update table entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < VECTOR_COUNT; i++) begin
      if (rst || clear) begin
        vaddr[i]  <= '0;
        vdata[i]  <= '0;
        masked[i] <= 1'b1;
      end else if (wr.en && wr.word[11:2] == 10'(i)) begin
        case (wr.word[1:0])
          MX_ADDR_LO: vaddr[i][31:0]  <= wr.data;
          MX_ADDR_HI: vaddr[i][63:32] <= wr.data;
          MX_DATA:    vdata[i]        <= wr.data;
          default:    masked[i]       <= wr.data[0];
        endcase
      end
    end
  end

  // Select read word and inject vector
  always_comb begin
    rd_data     = '0;
    sel_address = '0;
    sel_data    = '0;
    for (int i = 0; i < VECTOR_COUNT; i++) begin
      if (rd_word[11:2] == 10'(i)) begin
        case (rd_word[1:0])
          MX_ADDR_LO: rd_data = vaddr[i][31:0];
          MX_ADDR_HI: rd_data = vaddr[i][63:32];
          MX_DATA:    rd_data = vdata[i];
          default:    rd_data = {31'd0, masked[i]};
        endcase
      end
      if (sel[i]) begin
        sel_address = sel_address | vaddr[i];
        sel_data    = sel_data | vdata[i];
      end
    end
  end

endmodule
